// ----- sv/ccu_pkg.sv -----
// ----------------------------------------------------------------------------
// ccu_pkg
// shared widths, command codes and controller/datapath interface types for
// the combinatorial count unit
// ----------------------------------------------------------------------------
package ccu_pkg;

   // largest count taken from the request; larger counts saturate
   localparam int COUNT_MAX = 255;

   // request and result field widths
   localparam int CMD_W = 3;
   localparam int CNT_W = 8;
   localparam int VAL_W = 64;
   localparam int HALF_W = VAL_W / 2;

   // working count width, wide enough for n + k - 1 of the repetition mode
   localparam int AW = $clog2(2 * COUNT_MAX);

   // divider: eight quotient bits per cycle over a product padded to whole steps
   localparam int DIV_BITS = 8;
   localparam int DIV_STEPS = (VAL_W + AW + DIV_BITS - 1) / DIV_BITS;
   localparam int DW = DIV_STEPS * DIV_BITS;
   localparam int DCNT_W = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

   // index of a bit of k for the power mode
   localparam int BIT_W = $clog2(CNT_W);

   // request operation codes
   typedef enum logic [CMD_W-1:0] {
      CMD_BINOM  = 3'd0,
      CMD_ARRANGE = 3'd1,
      CMD_FACT   = 3'd2,
      CMD_REP    = 3'd3,
      CMD_POWER  = 3'd4
   } cmd_type;

   // datapath operations
   typedef enum logic [2:0] {
      DP_NOP,
      DP_SET,
      DP_MUL,
      DP_SQR,
      DP_DIV,
      DP_TAKE,
      DP_EMIT
   } dp_op_type;

   // controller to datapath command
   typedef struct packed {
      dp_op_type       op;
      logic            set_bit;
      logic [AW-1:0]   mul_a;
      logic [AW-1:0]   div_b;
      logic            emit_ovf;
   } dp_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic            acc_ovf;
   } dp_stat_type;

   // clamp a request count to COUNT_MAX
   function automatic logic [CNT_W-1:0] sat_count(input logic [CNT_W-1:0] x);
      logic [CNT_W-1:0] y;
      if (int'(x) > COUNT_MAX) begin
         y = CNT_W'(COUNT_MAX);
      end else begin
         y = x;
      end
      return y;
   endfunction

endpackage

// ----- sv/ccu_datapath.sv -----
// ----------------------------------------------------------------------------
// ccu_datapath
// running product register, small and half-width multipliers, radix-256
// restoring divider and the registered result value
// ----------------------------------------------------------------------------
module ccu_datapath (
   input  logic                        clock,
   input  ccu_pkg::dp_ctrl_type        ctrl,
   output ccu_pkg::dp_stat_type        stat,
   output logic [ccu_pkg::VAL_W-1:0]   value
);

   localparam int PW = ccu_pkg::VAL_W + ccu_pkg::AW;

   logic [ccu_pkg::VAL_W-1:0] r_ff, r_in;
   logic [ccu_pkg::DW-1:0]    acc_ff, acc_in;
   logic [ccu_pkg::AW-1:0]    rem_ff, rem_in;
   logic [ccu_pkg::VAL_W-1:0] val_ff, val_in;

   logic [PW-1:0]             mul_p;
   logic [ccu_pkg::VAL_W-1:0] sq_p;
   logic                      sq_hi;
   logic [ccu_pkg::DW-1:0]    div_acc;
   logic [ccu_pkg::AW-1:0]    div_rem;

   // running value times a small operand
   assign mul_p = PW'(r_ff) * PW'(ctrl.mul_a);

   // square of the low half; a nonzero high half means the square overflows
   assign sq_p  = ccu_pkg::VAL_W'(r_ff[ccu_pkg::HALF_W-1:0])
                * ccu_pkg::VAL_W'(r_ff[ccu_pkg::HALF_W-1:0]);
   assign sq_hi = |r_ff[ccu_pkg::VAL_W-1:ccu_pkg::HALF_W];

   // one divider cycle: shift eight dividend bits through the remainder
   always_comb begin
      logic [ccu_pkg::AW:0]   t;
      logic [ccu_pkg::DW-1:0] a_t;
      logic [ccu_pkg::AW-1:0] rm;
      a_t = acc_ff;
      rm  = rem_ff;
      for (int j = 0; j < ccu_pkg::DIV_BITS; j++) begin
         t   = {rm, a_t[ccu_pkg::DW-1]};
         a_t = {a_t[ccu_pkg::DW-2:0], 1'b0};
         if (t >= {1'b0, ctrl.div_b}) begin
            t      = t - {1'b0, ctrl.div_b};
            a_t[0] = 1'b1;
         end
         rm = t[ccu_pkg::AW-1:0];
      end
      div_acc = a_t;
      div_rem = rm;
   end

   // operation decode
   always_comb begin
      r_in   = r_ff;
      acc_in = acc_ff;
      rem_in = rem_ff;
      val_in = val_ff;
      case (ctrl.op)
         ccu_pkg::DP_SET: begin
            r_in = ccu_pkg::VAL_W'(ctrl.set_bit);
         end
         ccu_pkg::DP_MUL: begin
            acc_in = ccu_pkg::DW'(mul_p);
            rem_in = '0;
         end
         ccu_pkg::DP_SQR: begin
            acc_in = {(ccu_pkg::DW - ccu_pkg::VAL_W)'(sq_hi), sq_p};
         end
         ccu_pkg::DP_DIV: begin
            acc_in = div_acc;
            rem_in = div_rem;
         end
         ccu_pkg::DP_TAKE: begin
            r_in = acc_ff[ccu_pkg::VAL_W-1:0];
         end
         ccu_pkg::DP_EMIT: begin
            val_in = ctrl.emit_ovf ? '0 : r_ff;
         end
         default: begin
         end
      endcase
   end

   // payload registers
   always_ff @(posedge clock) begin
      r_ff   <= r_in;
      acc_ff <= acc_in;
      rem_ff <= rem_in;
      val_ff <= val_in;
   end

   // anything above the low word is an overflow
   assign stat.acc_ovf = |acc_ff[ccu_pkg::DW-1:ccu_pkg::VAL_W];
   assign value        = val_ff;

endmodule

// ----- sv/ccu_control.sv -----
// ----------------------------------------------------------------------------
// ccu_control
// request decode, loop counters and sequencing state machine
// ----------------------------------------------------------------------------
module ccu_control (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ccu_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ccu_pkg::CNT_W-1:0]     req_count_n,
   input  logic [ccu_pkg::CNT_W-1:0]     req_count_k,
   output ccu_pkg::dp_ctrl_type          ctrl,
   input  ccu_pkg::dp_stat_type          stat,
   output logic                          rsp_valid,
   output logic                          rsp_overflow
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_SETUP,
      S_LOOP,
      S_DIV,
      S_TAKE,
      S_PSQ,
      S_PSQT,
      S_PMUL,
      S_PMT,
      S_FIN
   } state_type;

   state_type                      state_ff, state_in;
   ccu_pkg::cmd_type               mode_ff, mode_in;
   logic [ccu_pkg::AW-1:0]         n_ff, n_in;
   logic [ccu_pkg::AW-1:0]         k_ff, k_in;
   logic                           zero_n_ff, zero_n_in;
   logic [ccu_pkg::AW-1:0]         base_ff, base_in;
   logic [ccu_pkg::AW-1:0]         cnt_ff, cnt_in;
   logic [ccu_pkg::AW-1:0]         i_ff, i_in;
   logic                           use_div_ff, use_div_in;
   logic [ccu_pkg::DCNT_W-1:0]     dcnt_ff, dcnt_in;
   logic [ccu_pkg::BIT_W-1:0]      bit_ff, bit_in;
   logic                           fin_ovf_ff, fin_ovf_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_overflow_ff, rsp_overflow_in;

   ccu_pkg::cmd_type               req_mode;
   logic [ccu_pkg::CNT_W-1:0]      n_sat;
   logic [ccu_pkg::CNT_W-1:0]      k_sat;
   logic [ccu_pkg::AW-1:0]         diff;
   logic [ccu_pkg::AW-1:0]         m_sel;
   logic                           k_gt_n;
   logic [ccu_pkg::CNT_W-1:0]      k_bits;

   // request decode
   assign req_mode = ccu_pkg::cmd_type'(req_cmd);
   assign n_sat    = ccu_pkg::sat_count(req_count_n);
   assign k_sat    = ccu_pkg::sat_count(req_count_k);

   // loop bounds from the latched counts
   assign k_gt_n = k_ff > n_ff;
   assign diff   = n_ff - k_ff;
   assign m_sel  = (k_ff < diff) ? k_ff : diff;
   assign k_bits = k_ff[ccu_pkg::CNT_W-1:0];

   // next state and datapath command
   always_comb begin
      state_in        = state_ff;
      mode_in         = mode_ff;
      n_in            = n_ff;
      k_in            = k_ff;
      zero_n_in       = zero_n_ff;
      base_in         = base_ff;
      cnt_in          = cnt_ff;
      i_in            = i_ff;
      use_div_in      = use_div_ff;
      dcnt_in         = dcnt_ff;
      bit_in          = bit_ff;
      fin_ovf_in      = fin_ovf_ff;
      rsp_valid_in    = 1'b0;
      rsp_overflow_in = rsp_overflow_ff;

      ctrl.op       = ccu_pkg::DP_NOP;
      ctrl.set_bit  = 1'b0;
      ctrl.mul_a    = base_ff + i_ff + ccu_pkg::AW'(1);
      ctrl.div_b    = i_ff;
      ctrl.emit_ovf = fin_ovf_ff;

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               mode_in   = req_mode;
               zero_n_in = (n_sat == '0);
               if (req_mode == ccu_pkg::CMD_REP) begin
                  n_in = ccu_pkg::AW'(n_sat) + ccu_pkg::AW'(k_sat) - ccu_pkg::AW'(1);
               end else begin
                  n_in = ccu_pkg::AW'(n_sat);
               end
               if (req_mode == ccu_pkg::CMD_FACT) begin
                  k_in = ccu_pkg::AW'(n_sat);
               end else begin
                  k_in = ccu_pkg::AW'(k_sat);
               end
               state_in = S_SETUP;
            end
         end

         // pick loop bounds or a direct answer
         S_SETUP: begin
            ctrl.op    = ccu_pkg::DP_SET;
            fin_ovf_in = 1'b0;
            i_in       = '0;
            case (mode_ff)
               ccu_pkg::CMD_BINOM, ccu_pkg::CMD_REP: begin
                  if (mode_ff == ccu_pkg::CMD_REP && zero_n_ff) begin
                     ctrl.set_bit = (k_ff == '0);
                     state_in     = S_FIN;
                  end else if (k_gt_n) begin
                     state_in = S_FIN;
                  end else begin
                     ctrl.set_bit = 1'b1;
                     base_in      = n_ff - m_sel;
                     cnt_in       = m_sel;
                     use_div_in   = 1'b1;
                     state_in     = S_LOOP;
                  end
               end
               ccu_pkg::CMD_ARRANGE, ccu_pkg::CMD_FACT: begin
                  if (k_gt_n) begin
                     state_in = S_FIN;
                  end else begin
                     ctrl.set_bit = 1'b1;
                     base_in      = diff;
                     cnt_in       = k_ff;
                     use_div_in   = 1'b0;
                     state_in     = S_LOOP;
                  end
               end
               ccu_pkg::CMD_POWER: begin
                  ctrl.set_bit = 1'b1;
                  bit_in       = ccu_pkg::BIT_W'(ccu_pkg::CNT_W - 1);
                  state_in     = S_PSQ;
               end
               default: begin
                  state_in = S_FIN;
               end
            endcase
         end

         // multiply by the next factor
         S_LOOP: begin
            if (i_ff == cnt_ff) begin
               state_in = S_FIN;
            end else begin
               ctrl.op = ccu_pkg::DP_MUL;
               i_in    = i_ff + ccu_pkg::AW'(1);
               dcnt_in = '0;
               state_in = use_div_ff ? S_DIV : S_TAKE;
            end
         end

         // exact divide by the step index
         S_DIV: begin
            ctrl.op = ccu_pkg::DP_DIV;
            dcnt_in = dcnt_ff + ccu_pkg::DCNT_W'(1);
            if (dcnt_ff == ccu_pkg::DCNT_W'(ccu_pkg::DIV_STEPS - 1)) begin
               state_in = S_TAKE;
            end
         end

         S_TAKE: begin
            if (stat.acc_ovf) begin
               fin_ovf_in = 1'b1;
               state_in   = S_FIN;
            end else begin
               ctrl.op  = ccu_pkg::DP_TAKE;
               state_in = S_LOOP;
            end
         end

         // square and multiply, top bit of k first
         S_PSQ: begin
            ctrl.op  = ccu_pkg::DP_SQR;
            state_in = S_PSQT;
         end

         S_PSQT: begin
            if (stat.acc_ovf) begin
               fin_ovf_in = 1'b1;
               state_in   = S_FIN;
            end else begin
               ctrl.op = ccu_pkg::DP_TAKE;
               if (k_bits[bit_ff]) begin
                  state_in = S_PMUL;
               end else if (bit_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  bit_in   = bit_ff - ccu_pkg::BIT_W'(1);
                  state_in = S_PSQ;
               end
            end
         end

         S_PMUL: begin
            ctrl.op    = ccu_pkg::DP_MUL;
            ctrl.mul_a = n_ff;
            state_in   = S_PMT;
         end

         S_PMT: begin
            if (stat.acc_ovf) begin
               fin_ovf_in = 1'b1;
               state_in   = S_FIN;
            end else begin
               ctrl.op = ccu_pkg::DP_TAKE;
               if (bit_ff == '0) begin
                  state_in = S_FIN;
               end else begin
                  bit_in   = bit_ff - ccu_pkg::BIT_W'(1);
                  state_in = S_PSQ;
               end
            end
         end

         // register the result and strobe it
         S_FIN: begin
            ctrl.op         = ccu_pkg::DP_EMIT;
            rsp_valid_in    = 1'b1;
            rsp_overflow_in = fin_ovf_ff;
            state_in        = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // state, counters and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         rsp_overflow_ff <= 1'b0;
         fin_ovf_ff      <= 1'b0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         rsp_overflow_ff <= rsp_overflow_in;
         fin_ovf_ff      <= fin_ovf_in;
      end
      mode_ff    <= mode_in;
      n_ff       <= n_in;
      k_ff       <= k_in;
      zero_n_ff  <= zero_n_in;
      base_ff    <= base_in;
      cnt_ff     <= cnt_in;
      i_ff       <= i_in;
      use_div_ff <= use_div_in;
      dcnt_ff    <= dcnt_in;
      bit_ff     <= bit_in;
   end

   assign busy         = (state_ff != S_IDLE);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_overflow = rsp_overflow_ff;

endmodule

// ----- sv/combinatorial_count_unit.sv -----
// ----------------------------------------------------------------------------
// combinatorial_count_unit
// binomial, arrangement, factorial, combination with repetition and power
// counts with 64-bit overflow detection
// ----------------------------------------------------------------------------
// binomial and repetition take m = min(k, n-k) steps, each one multiply and a
//    radix-256 divide; arrangement and factorial take k or n steps; the power
//    squares for every bit of k and multiplies for each set bit; a direct answer
//    is given for k above n, no kinds or an unused code; overflow ends early
// one request at a time: busy high until the one-cycle strobe, which cannot be stalled
// synchronous reset returns the sequencer to idle with no result pending
module combinatorial_count_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [ccu_pkg::CMD_W-1:0]     req_cmd,
   input  logic [ccu_pkg::CNT_W-1:0]     req_count_n,
   input  logic [ccu_pkg::CNT_W-1:0]     req_count_k,
   output logic                          rsp_valid,
   output logic [ccu_pkg::VAL_W-1:0]     rsp_value,
   output logic                          rsp_overflow
);

   ccu_pkg::dp_ctrl_type ctrl;
   ccu_pkg::dp_stat_type stat;

   // sequencer
   ccu_control u_control (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_count_n  (req_count_n),
      .req_count_k  (req_count_k),
      .ctrl         (ctrl),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_overflow (rsp_overflow)
   );

   // arithmetic
   ccu_datapath u_datapath (
      .clock (clock),
      .ctrl  (ctrl),
      .stat  (stat),
      .value (rsp_value)
   );

   // a result only follows a busy cycle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result strobe without a request in progress");

   // an accepted request makes the unit busy
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but unit not busy");

   // overflowed results carry a zero value
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |-> (rsp_value == '0))
      else $error("overflow result with nonzero value");

   // one strobe per request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

endmodule

// ----- tb/combinatorial_count_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// combinatorial_count_unit_tb
// sends directed and random count requests over the start/busy port, works
// out each count with exact wide arithmetic and checks every strobed result
// in request order, with random sender gaps and a stall watchdog
// ----------------------------------------------------------------------------
module combinatorial_count_unit_tb;

   localparam int CLOCK_HALF = 10;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_REQUESTS = 775;
   localparam int MAX_GAP = 6;
   // slowest request is a repetition count near 254 steps
   localparam int STALL_LIMIT = 16000;
   localparam int DRAIN_CYCLES = 40;
   localparam int WIDE_W = 2 * ccu_pkg::VAL_W;
   // command codes with no operation behind them
   localparam logic [ccu_pkg::CMD_W-1:0] CMD_SPARE_LO = 3'd5;
   localparam logic [ccu_pkg::CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   typedef struct {
      logic [ccu_pkg::CMD_W-1:0] cmd;
      logic [ccu_pkg::CNT_W-1:0] count_n;
      logic [ccu_pkg::CNT_W-1:0] count_k;
   } count_request_type;

   typedef struct {
      logic [ccu_pkg::VAL_W-1:0] value;
      logic                      overflow;
   } count_result_type;

   typedef struct {
      count_request_type req;
      count_result_type  res;
   } expected_count_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [ccu_pkg::CMD_W-1:0] req_cmd = '0;
   logic [ccu_pkg::CNT_W-1:0] req_count_n = '0;
   logic [ccu_pkg::CNT_W-1:0] req_count_k = '0;
   logic                      rsp_valid;
   logic [ccu_pkg::VAL_W-1:0] rsp_value;
   logic                      rsp_overflow;

   count_request_type   pending_q[$];
   expected_count_type  expected_q[$];
   int                  total_requests = 0;
   int                  accepted_count = 0;
   int                  mismatch_count = 0;
   int                  stall_cycles = 0;

   combinatorial_count_unit uut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_count_n  (req_count_n),
      .req_count_k  (req_count_k),
      .rsp_valid    (rsp_valid),
      .rsp_value    (rsp_value),
      .rsp_overflow (rsp_overflow)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // C(n,k) built step by step; each partial product divides exactly
   function automatic count_result_type binomial_count(input int n, input int k);
      count_result_type  r;
      logic [WIDE_W-1:0] acc;
      logic [WIDE_W-1:0] prod;
      int                m;
      r = '{value: '0, overflow: 1'b0};
      if (k > n) begin
         return r;
      end
      m = (k < n - k) ? k : n - k;
      acc = WIDE_W'(1);
      for (int i = 1; i <= m; i++) begin
         prod = (acc * WIDE_W'(n - m + i)) / WIDE_W'(i);
         if (prod[WIDE_W-1:ccu_pkg::VAL_W] != '0) begin
            r.overflow = 1'b1;
            return r;
         end
         acc = prod;
      end
      r.value = acc[ccu_pkg::VAL_W-1:0];
      return r;
   endfunction

   // n!/(n-k)! as a running product of n-k+1 .. n
   function automatic count_result_type arrangement_count(input int n, input int k);
      count_result_type  r;
      logic [WIDE_W-1:0] acc;
      r = '{value: '0, overflow: 1'b0};
      if (k > n) begin
         return r;
      end
      acc = WIDE_W'(1);
      for (int i = n - k + 1; i <= n; i++) begin
         acc = acc * WIDE_W'(i);
         if (acc[WIDE_W-1:ccu_pkg::VAL_W] != '0) begin
            r.overflow = 1'b1;
            return r;
         end
      end
      r.value = acc[ccu_pkg::VAL_W-1:0];
      return r;
   endfunction

   // n^k by square-and-multiply over a 16-bit exponent, msb first
   function automatic count_result_type power_count(input int n, input int k);
      count_result_type  r;
      logic [WIDE_W-1:0] acc;
      r = '{value: '0, overflow: 1'b0};
      acc = WIDE_W'(1);
      for (int b = 15; b >= 0; b--) begin
         acc = acc * acc;
         if (acc[WIDE_W-1:ccu_pkg::VAL_W] != '0) begin
            r.overflow = 1'b1;
            return r;
         end
         if (((k >> b) & 1) != 0) begin
            acc = acc * WIDE_W'(n);
            if (acc[WIDE_W-1:ccu_pkg::VAL_W] != '0) begin
               r.overflow = 1'b1;
               return r;
            end
         end
      end
      r.value = acc[ccu_pkg::VAL_W-1:0];
      return r;
   endfunction

   // expected count for one request
   function automatic count_result_type predict_count(input count_request_type req);
      count_result_type r;
      int               n;
      int               k;
      n = (int'(req.count_n) > ccu_pkg::COUNT_MAX) ? ccu_pkg::COUNT_MAX : int'(req.count_n);
      k = (int'(req.count_k) > ccu_pkg::COUNT_MAX) ? ccu_pkg::COUNT_MAX : int'(req.count_k);
      r = '{value: '0, overflow: 1'b0};
      case (req.cmd)
         ccu_pkg::CMD_BINOM: r = binomial_count(n, k);
         ccu_pkg::CMD_ARRANGE: r = arrangement_count(n, k);
         ccu_pkg::CMD_FACT: r = arrangement_count(n, n);
         ccu_pkg::CMD_REP: begin
            // no kinds to draw from: only the empty selection exists
            if (n == 0) begin
               r.value = (k == 0) ? ccu_pkg::VAL_W'(1) : ccu_pkg::VAL_W'(0);
            end else begin
               r = binomial_count(n + k - 1, k);
            end
         end
         ccu_pkg::CMD_POWER: r = power_count(n, k);
         default: r = '{value: '0, overflow: 1'b0};
      endcase
      return r;
   endfunction

   task automatic add_request(input logic [ccu_pkg::CMD_W-1:0] cmd,
                              input logic [ccu_pkg::CNT_W-1:0] n,
                              input logic [ccu_pkg::CNT_W-1:0] k);
      count_request_type req;
      req = '{cmd: cmd, count_n: n, count_k: k};
      pending_q = {pending_q, req};
   endtask

   task automatic report_mismatch(input string what);
      $display("%0t ns: %s", $realtime, what);
      mismatch_count++;
   endtask

   // request driver: hold each request until accepted, then wait a random gap
   count_request_type  next_req;
   expected_count_type accepted_req;
   logic               took;
   int                 gap;
   int                 gap_left = 0;
   int                 calm_left = 0;

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= 0;
      end else begin
         took = start && !busy;
         if (took) begin
            accepted_req.req = '{cmd: req_cmd, count_n: req_count_n, count_k: req_count_k};
            accepted_req.res = predict_count(accepted_req.req);
            expected_q = {expected_q, accepted_req};
            accepted_count++;
         end
         if (took || !start) begin
            if (!took) begin
               gap = gap_left;
            end else if (calm_left > 0) begin
               calm_left--;
               gap = 0;
            end else if ($urandom_range(0, 19) == 0) begin
               // back-to-back stretch
               calm_left = $urandom_range(10, 30);
               gap = 0;
            end else begin
               gap = $urandom_range(0, MAX_GAP);
            end
            if (gap == 0 && pending_q.size() != 0) begin
               next_req = pending_q.pop_front();
               req_cmd <= next_req.cmd;
               req_count_n <= next_req.count_n;
               req_count_k <= next_req.count_k;
               start <= 1'b1;
            end else begin
               start <= 1'b0;
               if (gap != 0) begin
                  gap_left <= gap - 1;
               end
            end
         end
      end
   end

   // result monitor: compare each strobe with the oldest expected count
   expected_count_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_q.size() == 0) begin
            report_mismatch($sformatf("result %0h ovf %0b with no request pending",
                                      rsp_value, rsp_overflow));
         end else begin
            want = expected_q.pop_front();
            if (rsp_value !== want.res.value) begin
               report_mismatch($sformatf("cmd %0d n %0d k %0d: value %0h, expected %0h",
                                         want.req.cmd, want.req.count_n, want.req.count_k,
                                         rsp_value, want.res.value));
            end
            if (rsp_overflow !== want.res.overflow) begin
               report_mismatch($sformatf("cmd %0d n %0d k %0d: overflow %0b, expected %0b",
                                         want.req.cmd, want.req.count_n, want.req.count_k,
                                         rsp_overflow, want.res.overflow));
            end
         end
      end
   end

   // watchdog on cycles with no request or result moving
   always @(posedge clock) begin
      if (!reset) begin
         if ((start && !busy) || rsp_valid) begin
            stall_cycles <= 0;
         end else if (stall_cycles >= STALL_LIMIT) begin
            $display("combinatorial_count_unit: mismatch");
            $finish;
         end else begin
            stall_cycles <= stall_cycles + 1;
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [ccu_pkg::CMD_W-1:0] cmd;
      logic [ccu_pkg::CNT_W-1:0] n;
      logic [ccu_pkg::CNT_W-1:0] k;
      int                        span;

      // field extremes and every operation
      add_request(ccu_pkg::CMD_BINOM, 8'd0, 8'd0);
      add_request(ccu_pkg::CMD_BINOM, 8'd255, 8'd255);
      add_request(ccu_pkg::CMD_BINOM, 8'd255, 8'd1);
      add_request(ccu_pkg::CMD_BINOM, 8'd67, 8'd33);
      add_request(ccu_pkg::CMD_BINOM, 8'd68, 8'd34);
      add_request(ccu_pkg::CMD_ARRANGE, 8'd20, 8'd20);
      add_request(ccu_pkg::CMD_ARRANGE, 8'd255, 8'd0);
      add_request(ccu_pkg::CMD_ARRANGE, 8'd255, 8'd255);
      // k above n
      add_request(ccu_pkg::CMD_BINOM, 8'd5, 8'd7);
      add_request(ccu_pkg::CMD_ARRANGE, 8'd0, 8'd255);
      // zero factorial, last fitting factorial, first overflowing one
      add_request(ccu_pkg::CMD_FACT, 8'd0, 8'd255);
      add_request(ccu_pkg::CMD_FACT, 8'd20, 8'd0);
      add_request(ccu_pkg::CMD_FACT, 8'd21, 8'd0);
      add_request(ccu_pkg::CMD_FACT, 8'd255, 8'd255);
      // repetition with no kinds, one kind and the field maximum
      add_request(ccu_pkg::CMD_REP, 8'd0, 8'd0);
      add_request(ccu_pkg::CMD_REP, 8'd0, 8'd5);
      add_request(ccu_pkg::CMD_REP, 8'd1, 8'd255);
      add_request(ccu_pkg::CMD_REP, 8'd255, 8'd255);
      // zero exponent, zero base and the 64-bit power edge
      add_request(ccu_pkg::CMD_POWER, 8'd0, 8'd0);
      add_request(ccu_pkg::CMD_POWER, 8'd0, 8'd255);
      add_request(ccu_pkg::CMD_POWER, 8'd255, 8'd0);
      add_request(ccu_pkg::CMD_POWER, 8'd2, 8'd63);
      add_request(ccu_pkg::CMD_POWER, 8'd2, 8'd64);
      add_request(ccu_pkg::CMD_POWER, 8'd255, 8'd8);
      add_request(ccu_pkg::CMD_POWER, 8'd255, 8'd9);
      // unused command codes
      add_request(CMD_SPARE_LO, 8'd10, 8'd3);
      add_request(CMD_SPARE_HI, 8'd255, 8'd255);

      // random requests, mostly small counts to keep the long modes short
      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if ($urandom_range(0, 99) < 3) begin
            cmd = ccu_pkg::CMD_W'($urandom_range(CMD_SPARE_LO, CMD_SPARE_HI));
         end else begin
            cmd = ccu_pkg::CMD_W'($urandom_range(ccu_pkg::CMD_BINOM, ccu_pkg::CMD_POWER));
         end
         span = $urandom_range(0, 9);
         if (span < 6) begin
            n = ccu_pkg::CNT_W'($urandom_range(0, 40));
            k = ccu_pkg::CNT_W'($urandom_range(0, 40));
         end else if (span < 9) begin
            n = ccu_pkg::CNT_W'($urandom_range(0, 100));
            k = ccu_pkg::CNT_W'($urandom_range(0, 100));
         end else begin
            n = ccu_pkg::CNT_W'($urandom_range(0, 255));
            k = ccu_pkg::CNT_W'($urandom_range(0, 255));
         end
         // keep most selections within n so the counts are non-trivial
         if ((cmd == ccu_pkg::CMD_BINOM || cmd == ccu_pkg::CMD_ARRANGE)
             && $urandom_range(0, 3) != 0) begin
            k = ccu_pkg::CNT_W'($urandom_range(0, n));
         end
         add_request(cmd, n, k);
      end
      total_requests = pending_q.size();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      while (accepted_count < total_requests || expected_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("combinatorial_count_unit: match");
      end else begin
         $display("combinatorial_count_unit: mismatch");
      end
      $finish;
   end

endmodule
